// ===== design/cpt_pkg.sv =====
// shared constants and types of the closest point on triangle pipeline
package cpt_pkg;

    localparam int CPT_COORD_WIDTH = 32;
    localparam int CPT_FRAC_BITS   = 16;
    // limb width of the split wide multipliers
    localparam int CPT_LIMB        = 32;

    typedef enum logic [2:0] {
        REG_VA  = 3'd0,
        REG_VB  = 3'd1,
        REG_EAB = 3'd2,
        REG_VC  = 3'd3,
        REG_EAC = 3'd4,
        REG_EBC = 3'd5,
        REG_IN  = 3'd6
    } t_region;

endpackage

// ===== design/cpt_in_if.sv =====
// input channel: query point and triangle vertices
interface cpt_in_if import cpt_pkg::*; #(
    parameter int COORD_WIDTH = CPT_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic signed [COORD_WIDTH-1:0] vert_a_x;
    logic signed [COORD_WIDTH-1:0] vert_a_y;
    logic signed [COORD_WIDTH-1:0] vert_a_z;
    logic signed [COORD_WIDTH-1:0] vert_b_x;
    logic signed [COORD_WIDTH-1:0] vert_b_y;
    logic signed [COORD_WIDTH-1:0] vert_b_z;
    logic signed [COORD_WIDTH-1:0] vert_c_x;
    logic signed [COORD_WIDTH-1:0] vert_c_y;
    logic signed [COORD_WIDTH-1:0] vert_c_z;

    modport source (
        output valid, point_x, point_y, point_z,
        output vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
        output vert_c_x, vert_c_y, vert_c_z,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z,
        input  vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
        input  vert_c_x, vert_c_y, vert_c_z,
        output ready
    );
endinterface

// ===== design/cpt_out_if.sv =====
// output channel: closest point, region and degenerate flag
interface cpt_out_if import cpt_pkg::*; #(
    parameter int COORD_WIDTH = CPT_COORD_WIDTH
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] near_x;
    logic signed [COORD_WIDTH-1:0] near_y;
    logic signed [COORD_WIDTH-1:0] near_z;
    logic [2:0]                    region;
    logic                          degenerate;

    modport source (
        output valid, near_x, near_y, near_z, region, degenerate,
        input  ready
    );
    modport sink (
        input  valid, near_x, near_y, near_z, region, degenerate,
        output ready
    );
endinterface

// ===== design/cpt_mul.sv =====
// three stage signed multiplier built from limb partial products
module cpt_mul import cpt_pkg::*; #(
    parameter int AW = 2 * CPT_COORD_WIDTH + 4,
    parameter int BW = 2 * CPT_COORD_WIDTH + 4,
    parameter int LB = CPT_LIMB
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int NA = (AW + LB - 1) / LB;
    localparam int NB = (BW + LB - 1) / LB;
    localparam int RW = AW + BW;
    localparam int XA = NA * LB;
    localparam int XB = NB * LB;
    localparam int PPW = 2 * LB + 2;

    logic signed [XA-1:0]     a_ext;
    logic signed [XB-1:0]     b_ext;
    logic signed [LB:0]       a_limb [NA];
    logic signed [LB:0]       b_limb [NB];
    logic signed [2*LB+1:0]   r_pp   [NA][NB];
    logic signed [RW-1:0]     n_row  [NA];
    logic signed [RW-1:0]     r_row  [NA];
    logic signed [RW-1:0]     n_p;
    logic signed [RW-1:0]     r_p;

    assign a_ext = XA'(i_a);
    assign b_ext = XB'(i_b);

    // low limbs unsigned, top limb carries the sign
    for (genvar i = 0; i < NA; i++) begin : g_alimb
        if (i == NA - 1) begin : g_top
            assign a_limb[i] = {a_ext[XA-1], a_ext[i*LB +: LB]};
        end else begin : g_low
            assign a_limb[i] = {1'b0, a_ext[i*LB +: LB]};
        end
    end
    for (genvar j = 0; j < NB; j++) begin : g_blimb
        if (j == NB - 1) begin : g_top
            assign b_limb[j] = {b_ext[XB-1], b_ext[j*LB +: LB]};
        end else begin : g_low
            assign b_limb[j] = {1'b0, b_ext[j*LB +: LB]};
        end
    end

    // partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= PPW'(a_limb[i]) * PPW'(b_limb[j]);
                end
            end
        end
    end

    // row sums
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (RW'(r_pp[i][j]) << (j * LB));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
        end
    end

    // final sum of rows
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (r_row[i] << (i * LB));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/cpt_div.sv =====
// pipelined restoring divider, one quotient bit per stage, two lanes on one divisor
module cpt_div import cpt_pkg::*; #(
    parameter int NW = 4 * CPT_COORD_WIDTH + 10,
    parameter int QW = CPT_FRAC_BITS + 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num0,
    input  logic [NW-1:0] i_num1,
    input  logic [NW-1:0] i_den,
    output logic [QW-1:0] o_q0,
    output logic [QW-1:0] o_q1,
    output logic          o_zero
);
    logic [NW-1:0] r_den  [QW];
    logic          r_zero [QW];
    logic [NW-1:0] r_rem  [QW][2];
    logic [QW-1:0] r_q    [QW][2];
    logic [NW-1:0] s_den  [QW];
    logic          s_zero [QW];
    logic [NW:0]   s_x    [QW][2];
    logic [QW-1:0] s_q    [QW][2];
    logic [NW-1:0] n_rem  [QW][2];
    logic [QW-1:0] n_q    [QW][2];

    // stage inputs
    always_comb begin
        s_den[0]   = i_den;
        s_zero[0]  = (i_den == '0);
        s_x[0][0]  = {1'b0, i_num0};
        s_x[0][1]  = {1'b0, i_num1};
        s_q[0][0]  = '0;
        s_q[0][1]  = '0;
        for (int k = 1; k < QW; k++) begin
            s_den[k]  = r_den[k-1];
            s_zero[k] = r_zero[k-1];
            for (int l = 0; l < 2; l++) begin
                s_x[k][l] = {r_rem[k-1][l], 1'b0};
                s_q[k][l] = r_q[k-1][l];
            end
        end
    end

    // compare and subtract, one bit per stage
    always_comb begin
        logic ge;
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < 2; l++) begin
                ge = (s_x[k][l] >= {1'b0, s_den[k]});
                if (ge) begin
                    n_rem[k][l] = NW'(s_x[k][l] - {1'b0, s_den[k]});
                    n_q[k][l]   = s_q[k][l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[k][l] = s_x[k][l][NW-1:0];
                    n_q[k][l]   = s_q[k][l];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den  <= s_den;
            r_zero <= s_zero;
            r_rem  <= n_rem;
            r_q    <= n_q;
        end
    end

    // a zero divisor gives a zero parameter
    assign o_q0   = r_zero[QW-1] ? '0 : r_q[QW-1][0];
    assign o_q1   = r_zero[QW-1] ? '0 : r_q[QW-1][1];
    assign o_zero = r_zero[QW-1];

endmodule

// ===== design/closest_point_on_triangle.sv =====
// Closest point on a triangle to a query point, signed fixed point, fully pipelined.
// One item enters per cycle unless the pipeline is stalled. The pipeline depth is set
// mostly by the parameter divider, which resolves one quotient bit per stage, and by
// the three stage wide multipliers that form the region cross terms. The output
// register and a one-entry skid stage keep the input open while a finished result
// waits; the pipeline stalls as a whole only when both are full. Edge and interior
// parameters are truncated to FRAC_BITS fraction bits; a zero interior denominator
// returns vertex A with the degenerate flag set.
module closest_point_on_triangle import cpt_pkg::*; #(
    parameter int COORD_WIDTH = CPT_COORD_WIDTH,
    parameter int FRAC_BITS   = CPT_FRAC_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cpt_in_if.sink    i_item,
    cpt_out_if.source o_item
);
    localparam int CW  = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int EW  = CW + 1;
    localparam int PW  = 2 * EW;
    localparam int DW  = PW + 2;
    localparam int MW  = 2 * DW;
    localparam int VW  = MW + 1;
    localparam int SW  = VW + 2;
    localparam int NW  = SW - 1;
    localparam int QW  = F + 1;
    localparam int TW  = F + 2;
    localparam int XW  = EW + TW;
    localparam int UW  = XW + 2;
    localparam int NST = 10 + QW;
    localparam int MA [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MB [6] = '{3, 1, 1, 5, 5, 3};

    typedef logic [2:0][CW-1:0] t_vec;
    typedef logic [2:0][EW-1:0] t_dvec;
    typedef struct packed {
        t_vec  a;
        t_vec  b;
        t_vec  c;
        t_dvec ab;
        t_dvec ac;
        t_dvec bc;
    } t_geo;
    typedef struct packed {
        t_region region;
        t_vec    base;
        t_dvec   dir0;
        t_dvec   dir1;
    } t_sel;
    typedef struct packed {
        t_vec    near;
        t_region region;
        logic    degen;
    } t_res;

    logic                 en;
    logic                 p_vld;
    logic [NST-1:0]       r_vld;

    t_vec                 r1_p, r1_a, r1_b, r1_c;
    t_geo                 n2_geo, r2_geo;
    t_dvec                n2_ap, n2_bp, n2_cp, r2_ap, r2_bp, r2_cp;
    logic signed [PW-1:0] n3_pr [6][3];
    logic signed [PW-1:0] r3_pr [6][3];
    t_geo                 r3_geo;
    logic signed [DW-1:0] n4_d [6];
    logic signed [DW-1:0] r4_d [6];
    t_geo                 r4_geo;
    logic signed [MW-1:0] m_p [6];
    logic signed [DW-1:0] r_dm_d [3][6];
    t_geo                 r_dm_geo [3];
    logic signed [VW-1:0] r8_va, r8_vb, r8_vc;
    logic signed [DW:0]   r8_e43, r8_e56;
    logic signed [DW-1:0] r8_d [6];
    t_geo                 r8_geo;
    t_sel                 n9_sel, r9_sel;
    logic signed [SW-1:0] c_num0, c_num1, c_den;
    logic [NW-1:0]        r9_num0, r9_num1, r9_den;
    logic [QW-1:0]        dv_q0, dv_q1;
    logic                 dv_zero;
    t_sel                 r_dv_sel [QW];
    logic signed [XW-1:0] n_pr0 [3];
    logic signed [XW-1:0] n_pr1 [3];
    logic signed [XW-1:0] rm_pr0 [3];
    logic signed [XW-1:0] rm_pr1 [3];
    t_sel                 rm_sel;
    logic                 rm_degen;
    t_res                 n_res, r_out, r_skd;
    logic                 r_ovld, r_svld;

    // whole pipeline advances unless the skid stage is holding an item
    assign en           = !r_svld;
    assign p_vld        = r_vld[NST-1];
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_item.valid};
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_p <= {i_item.point_z, i_item.point_y, i_item.point_x};
            r1_a <= {i_item.vert_a_z, i_item.vert_a_y, i_item.vert_a_x};
            r1_b <= {i_item.vert_b_z, i_item.vert_b_y, i_item.vert_b_x};
            r1_c <= {i_item.vert_c_z, i_item.vert_c_y, i_item.vert_c_x};
        end
    end

    // edge and offset vectors
    always_comb begin
        n2_geo.a = r1_a;
        n2_geo.b = r1_b;
        n2_geo.c = r1_c;
        for (int k = 0; k < 3; k++) begin
            n2_geo.ab[k] = EW'($signed(r1_b[k])) - EW'($signed(r1_a[k]));
            n2_geo.ac[k] = EW'($signed(r1_c[k])) - EW'($signed(r1_a[k]));
            n2_geo.bc[k] = EW'($signed(r1_c[k])) - EW'($signed(r1_b[k]));
            n2_ap[k]     = EW'($signed(r1_p[k])) - EW'($signed(r1_a[k]));
            n2_bp[k]     = EW'($signed(r1_p[k])) - EW'($signed(r1_b[k]));
            n2_cp[k]     = EW'($signed(r1_p[k])) - EW'($signed(r1_c[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_geo <= n2_geo;
            r2_ap  <= n2_ap;
            r2_bp  <= n2_bp;
            r2_cp  <= n2_cp;
        end
    end

    // dot product terms: even rows use ab, odd rows ac; pairs walk ap, bp, cp
    always_comb begin
        logic signed [EW-1:0] su;
        logic signed [EW-1:0] sv;
        for (int n = 0; n < 6; n++) begin
            for (int k = 0; k < 3; k++) begin
                su = ((n & 1) == 0) ? $signed(r2_geo.ab[k]) : $signed(r2_geo.ac[k]);
                sv = ((n >> 1) == 0) ? $signed(r2_ap[k]) :
                     ((n >> 1) == 1) ? $signed(r2_bp[k]) : $signed(r2_cp[k]);
                n3_pr[n][k] = PW'(su) * PW'(sv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_pr  <= n3_pr;
            r3_geo <= r2_geo;
        end
    end

    // d1 .. d6
    always_comb begin
        for (int n = 0; n < 6; n++) begin
            n4_d[n] = DW'(r3_pr[n][0]) + DW'(r3_pr[n][1]) + DW'(r3_pr[n][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_d   <= n4_d;
            r4_geo <= r3_geo;
        end
    end

    // cross terms of the region tests
    for (genvar m = 0; m < 6; m++) begin : g_mul
        cpt_mul #(
            .AW (DW),
            .BW (DW),
            .LB (CPT_LIMB)
        ) u_mul (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r4_d[MA[m]]),
            .i_b   (r4_d[MB[m]]),
            .o_p   (m_p[m])
        );
    end

    // side data alongside the multipliers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dm_d[0]   <= r4_d;
            r_dm_geo[0] <= r4_geo;
            for (int s = 1; s < 3; s++) begin
                r_dm_d[s]   <= r_dm_d[s-1];
                r_dm_geo[s] <= r_dm_geo[s-1];
            end
        end
    end

    // barycentric numerators and edge differences
    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_vc  <= VW'(m_p[0]) - VW'(m_p[1]);
            r8_vb  <= VW'(m_p[2]) - VW'(m_p[3]);
            r8_va  <= VW'(m_p[4]) - VW'(m_p[5]);
            r8_e43 <= (DW+1)'(r_dm_d[2][3]) - (DW+1)'(r_dm_d[2][2]);
            r8_e56 <= (DW+1)'(r_dm_d[2][4]) - (DW+1)'(r_dm_d[2][5]);
            r8_d   <= r_dm_d[2];
            r8_geo <= r_dm_geo[2];
        end
    end

    // region choice in test order, and setup of base, directions and divider operands
    always_comb begin
        logic d1_le, d2_le, d3_le, d6_le, d1_ge, d2_ge, d3_ge, d6_ge;
        logic e43_le, e43_ge, e56_le, e56_ge, va_le, vb_le, vc_le;
        d1_le  = r8_d[0][DW-1] || (r8_d[0] == '0);
        d2_le  = r8_d[1][DW-1] || (r8_d[1] == '0);
        d3_le  = r8_d[2][DW-1] || (r8_d[2] == '0);
        d6_le  = r8_d[5][DW-1] || (r8_d[5] == '0);
        d1_ge  = !r8_d[0][DW-1];
        d2_ge  = !r8_d[1][DW-1];
        d3_ge  = !r8_d[2][DW-1];
        d6_ge  = !r8_d[5][DW-1];
        e43_le = r8_e43[DW] || (r8_e43 == '0);
        e43_ge = !r8_e43[DW];
        e56_le = r8_e56[DW] || (r8_e56 == '0);
        e56_ge = !r8_e56[DW];
        va_le  = r8_va[VW-1] || (r8_va == '0);
        vb_le  = r8_vb[VW-1] || (r8_vb == '0);
        vc_le  = r8_vc[VW-1] || (r8_vc == '0);

        n9_sel.region = REG_IN;
        n9_sel.base   = r8_geo.a;
        n9_sel.dir0   = '0;
        n9_sel.dir1   = '0;
        c_num0        = '0;
        c_num1        = '0;
        c_den         = '0;
        priority if (d1_le && d2_le) begin
            n9_sel.region = REG_VA;
        end else if (d3_ge && e43_le) begin
            n9_sel.region = REG_VB;
            n9_sel.base   = r8_geo.b;
        end else if (vc_le && d1_ge && d3_le) begin
            n9_sel.region = REG_EAB;
            n9_sel.dir0   = r8_geo.ab;
            c_num0        = SW'(r8_d[0]);
            c_den         = SW'(r8_d[0]) - SW'(r8_d[2]);
        end else if (d6_ge && e56_le) begin
            n9_sel.region = REG_VC;
            n9_sel.base   = r8_geo.c;
        end else if (vb_le && d2_ge && d6_le) begin
            n9_sel.region = REG_EAC;
            n9_sel.dir0   = r8_geo.ac;
            c_num0        = SW'(r8_d[1]);
            c_den         = SW'(r8_d[1]) - SW'(r8_d[5]);
        end else if (va_le && e43_ge && e56_ge) begin
            n9_sel.region = REG_EBC;
            n9_sel.base   = r8_geo.b;
            n9_sel.dir0   = r8_geo.bc;
            c_num0        = SW'(r8_e43);
            c_den         = SW'(r8_e43) + SW'(r8_e56);
        end else begin
            n9_sel.dir0   = r8_geo.ab;
            n9_sel.dir1   = r8_geo.ac;
            c_num0        = SW'(r8_vb);
            c_num1        = SW'(r8_vc);
            c_den         = SW'(r8_va) + SW'(r8_vb) + SW'(r8_vc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_sel  <= n9_sel;
            r9_num0 <= c_num0[NW-1:0];
            r9_num1 <= c_num1[NW-1:0];
            r9_den  <= c_den[NW-1:0];
        end
    end

    // edge and barycentric parameters
    cpt_div #(
        .NW (NW),
        .QW (QW)
    ) u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num0 (r9_num0),
        .i_num1 (r9_num1),
        .i_den  (r9_den),
        .o_q0   (dv_q0),
        .o_q1   (dv_q1),
        .o_zero (dv_zero)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_sel[0] <= r9_sel;
            for (int s = 1; s < QW; s++) begin
                r_dv_sel[s] <= r_dv_sel[s-1];
            end
        end
    end

    // direction times parameter
    always_comb begin
        logic signed [TW-1:0] t0;
        logic signed [TW-1:0] t1;
        t0 = {1'b0, dv_q0};
        t1 = {1'b0, dv_q1};
        for (int k = 0; k < 3; k++) begin
            n_pr0[k] = XW'($signed(r_dv_sel[QW-1].dir0[k])) * XW'(t0);
            n_pr1[k] = XW'($signed(r_dv_sel[QW-1].dir1[k])) * XW'(t1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rm_pr0   <= n_pr0;
            rm_pr1   <= n_pr1;
            rm_sel   <= r_dv_sel[QW-1];
            rm_degen <= (r_dv_sel[QW-1].region == REG_IN) && dv_zero;
        end
    end

    // base plus scaled directions, floor shift back to the coordinate format
    always_comb begin
        logic signed [UW-1:0] acc;
        for (int k = 0; k < 3; k++) begin
            acc = UW'($signed({rm_sel.base[k], {F{1'b0}}})) + UW'(rm_pr0[k])
                + UW'(rm_pr1[k]);
            n_res.near[k] = acc[F +: CW];
        end
        n_res.region = rm_sel.region;
        n_res.degen  = rm_degen;
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else if (r_ovld && !o_item.ready) begin
            if (en && p_vld) begin
                r_svld <= 1'b1;
            end
        end else if (r_svld) begin
            r_ovld <= 1'b1;
            r_svld <= 1'b0;
        end else begin
            r_ovld <= en && p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!(r_ovld && !o_item.ready)) begin
            r_out <= r_svld ? r_skd : n_res;
        end
        if (r_ovld && !o_item.ready && en) begin
            r_skd <= n_res;
        end
    end

    assign o_item.valid      = r_ovld;
    assign o_item.near_x     = r_out.near[0];
    assign o_item.near_y     = r_out.near[1];
    assign o_item.near_z     = r_out.near[2];
    assign o_item.region     = r_out.region;
    assign o_item.degenerate = r_out.degen;

    // skid stage is only filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svld |-> r_ovld)
        else $error("skid stage holds an item while the output register is empty");

    // a full skid stage with a stalled output freezes the pipeline
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_svld && !o_item.ready) |=> $stable(r_vld))
        else $error("pipeline moved while the output side was full");

    // degenerate results only come from the interior region
    a_degen_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && o_item.degenerate) |-> (o_item.region == REG_IN))
        else $error("degenerate flag outside the interior region");

endmodule

// ===== bench/tb_closest_point_on_triangle.sv =====
// self-checking testbench of the closest point on triangle pipeline
module tb_closest_point_on_triangle;
    import cpt_pkg::*;

    localparam int CW       = CPT_COORD_WIDTH;
    localparam int FB       = CPT_FRAC_BITS;
    localparam int N_RANDOM = 1250;
    localparam int IDLE_MAX = 3000;
    localparam int DRAIN    = 40;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    typedef struct {
        coord_t p [3];
        coord_t a [3];
        coord_t b [3];
        coord_t c [3];
    } query_t;

    typedef struct {
        coord_t  near [3];
        t_region region;
        logic    degenerate;
    } nearest_t;

    // exact geometry helpers
    function automatic wide_t dot3(wide_t u [3], wide_t v [3]);
        dot3 = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // (num << FB) / den truncated toward zero, 0 for a zero denominator
    function automatic wide_t edge_param(wide_t num, wide_t den);
        if (den == 0) begin
            edge_param = '0;
        end else begin
            edge_param = (num <<< FB) / den;
        end
    endfunction

    function automatic coord_t clamp_coord(wide_t x);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (CW - 1)) - 1;
        lo = -(wide_t'(1) <<< (CW - 1));
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        clamp_coord = x[CW-1:0];
    endfunction

    // closest point by Voronoi region, tested in the block's order
    function automatic nearest_t nearest_point(query_t q);
        wide_t p [3], a [3], b [3], c [3];
        wide_t ab [3], ac [3], ap [3], bp [3], cp [3], bc [3];
        wide_t res [3];
        wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, t, t2, den;
        nearest_t r;
        for (int k = 0; k < 3; k++) begin
            p[k] = wide_t'(q.p[k]);
            a[k] = wide_t'(q.a[k]);
            b[k] = wide_t'(q.b[k]);
            c[k] = wide_t'(q.c[k]);
            ab[k] = b[k] - a[k];
            ac[k] = c[k] - a[k];
            ap[k] = p[k] - a[k];
            bp[k] = p[k] - b[k];
            cp[k] = p[k] - c[k];
            bc[k] = c[k] - b[k];
            res[k] = a[k];
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        r.degenerate = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            r.region = REG_VA;
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            r.region = REG_VB;
            for (int k = 0; k < 3; k++) res[k] = b[k];
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            r.region = REG_EAB;
            t = edge_param(d1, d1 - d3);
            for (int k = 0; k < 3; k++) res[k] = ((a[k] <<< FB) + ab[k] * t) >>> FB;
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            r.region = REG_VC;
            for (int k = 0; k < 3; k++) res[k] = c[k];
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            r.region = REG_EAC;
            t = edge_param(d2, d2 - d6);
            for (int k = 0; k < 3; k++) res[k] = ((a[k] <<< FB) + ac[k] * t) >>> FB;
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            r.region = REG_EBC;
            t = edge_param(d4 - d3, (d4 - d3) + (d5 - d6));
            for (int k = 0; k < 3; k++) res[k] = ((b[k] <<< FB) + bc[k] * t) >>> FB;
        end else begin
            r.region = REG_IN;
            den = va + vb + vc;
            if (den == 0) begin
                r.degenerate = 1'b1;
            end else begin
                t  = edge_param(vb, den);
                t2 = edge_param(vc, den);
                for (int k = 0; k < 3; k++)
                    res[k] = ((a[k] <<< FB) + ab[k] * t + ac[k] * t2) >>> FB;
            end
        end
        for (int k = 0; k < 3; k++) r.near[k] = clamp_coord(res[k]);
        return r;
    endfunction

    // expected results in order of acceptance
    class nearest_board;
        nearest_t pending [$];
        int       errors;
        int       checked;
        int       region_seen [7];
        int       degen_seen;

        task report(string what, int got, int want);
            errors++;
            $display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got, want);
        endtask

        function void note_query(query_t q);
            pending.push_back(nearest_point(q));
        endfunction

        task check_result(coord_t nx, coord_t ny, coord_t nz, logic [2:0] reg_code, logic dg);
            nearest_t e;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = pending.pop_front();
                if (nx !== e.near[0]) report("near_x", nx, e.near[0]);
                if (ny !== e.near[1]) report("near_y", ny, e.near[1]);
                if (nz !== e.near[2]) report("near_z", nz, e.near[2]);
                if (reg_code !== e.region) report("region", int'(reg_code), int'(e.region));
                if (dg !== e.degenerate) report("degenerate", int'(dg), int'(e.degenerate));
                region_seen[e.region]++;
                if (e.degenerate) degen_seen++;
            end
            checked++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    nearest_board board;
    bit   no_idle;
    int   idle_cycles;
    int   sent;

    cpt_in_if  in_ch ();
    cpt_out_if out_ch ();

    closest_point_on_triangle i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_item  (out_ch)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int draw_gap();
        if (no_idle || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // drive one item and wait for its acceptance
    task automatic send_query(query_t q);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.point_x  <= q.p[0];
        in_ch.point_y  <= q.p[1];
        in_ch.point_z  <= q.p[2];
        in_ch.vert_a_x <= q.a[0];
        in_ch.vert_a_y <= q.a[1];
        in_ch.vert_a_z <= q.a[2];
        in_ch.vert_b_x <= q.b[0];
        in_ch.vert_b_y <= q.b[1];
        in_ch.vert_b_z <= q.b[2];
        in_ch.vert_c_x <= q.c[0];
        in_ch.vert_c_y <= q.c[1];
        in_ch.vert_c_z <= q.c[2];
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_query(q);
        sent++;
    endtask

    function automatic coord_t span_coord(int span);
        return coord_t'($signed($urandom_range(0, 2 * span))) - coord_t'(span);
    endfunction

    // random query: full range, moderate triangles, small grid, coincident vertices
    function automatic query_t random_query();
        query_t q;
        int     kind;
        int     span;
        coord_t centre;
        kind = $urandom_range(0, 9);
        for (int k = 0; k < 3; k++) begin
            if (kind == 0) begin
                q.p[k] = $urandom; q.a[k] = $urandom; q.b[k] = $urandom; q.c[k] = $urandom;
            end else if (kind <= 6) begin
                span   = 1 << $urandom_range(4, 24);
                centre = span_coord(1 << 28);
                q.a[k] = centre + span_coord(span);
                q.b[k] = centre + span_coord(span);
                q.c[k] = centre + span_coord(span);
                q.p[k] = centre + span_coord(2 * span);
            end else if (kind <= 8) begin
                q.a[k] = span_coord(2) <<< FB;
                q.b[k] = span_coord(2) <<< FB;
                q.c[k] = span_coord(2) <<< FB;
                q.p[k] = span_coord(3) <<< (FB - 1);
            end else begin
                q.a[k] = span_coord(1 << 20);
                q.b[k] = q.a[k];
                q.c[k] = ($urandom_range(0, 1) != 0) ? q.a[k] : span_coord(1 << 20);
                q.p[k] = span_coord(1 << 21);
            end
        end
        return q;
    endfunction

    function automatic query_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                          int bx, int by, int bz, int cx, int cy, int cz);
        query_t q;
        q.p[0] = px; q.p[1] = py; q.p[2] = pz;
        q.a[0] = ax; q.a[1] = ay; q.a[2] = az;
        q.b[0] = bx; q.b[1] = by; q.b[2] = bz;
        q.c[0] = cx; q.c[1] = cy; q.c[2] = cz;
        return q;
    endfunction

    // result side with random stalls
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            int stall;
            stall = draw_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            board.check_result(out_ch.near_x, out_ch.near_y, out_ch.near_z,
                               out_ch.region, out_ch.degenerate);
        end
    end

    // watchdog on cycles with no accepted item or result
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_MAX) begin
                $display("timeout with %0d results outstanding", board.pending.size());
                $display("[closest_point_on_triangle] ERROR");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        localparam int ONE = 1 << FB;
        query_t directed [$];
        board       = new();
        no_idle     = 1'b0;
        idle_cycles = 0;
        sent        = 0;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
        in_ch.vert_a_x = '0; in_ch.vert_a_y = '0; in_ch.vert_a_z = '0;
        in_ch.vert_b_x = '0; in_ch.vert_b_y = '0; in_ch.vert_b_z = '0;
        in_ch.vert_c_x = '0; in_ch.vert_c_y = '0; in_ch.vert_c_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // each region, extremes, coincident and collinear vertices
        directed.push_back(make_query(-ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(3 * ONE, -ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(ONE / 2, -ONE, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(-ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(-ONE, ONE / 3, 0, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(ONE, ONE, -ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(ONE / 4, ONE / 4, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE, 0));
        directed.push_back(make_query(5, 7, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_query(ONE, ONE, 0, 0, 0, 0, 0, 0, 0, 2 * ONE, 0, 0));
        directed.push_back(make_query(ONE / 2, ONE, 0, 0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0));
        directed.push_back(make_query(ONE, 0, 0, 0, 0, 0, ONE, 0, 0, ONE, 0, 0));
        directed.push_back(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff, 32'h7fffffff));
        directed.push_back(make_query(32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000, 32'h7fffffff, 32'h80000000,
                                      32'h7fffffff, 32'h80000000, 32'h80000000));
        directed.push_back(make_query(0, 0, 32'h7fffffff, 32'h80000000, 32'h80000000, 0,
                                      32'h7fffffff, 32'h80000000, 0,
                                      0, 32'h7fffffff, 0));
        directed.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        directed.push_back(make_query(1, 2, 3, 0, 0, 0, 1, 0, 0, 0, 1, 0));
        foreach (directed[i]) send_query(directed[i]);
        in_ch.valid <= 1'b0;

        // hold the sender until everything has drained
        while (board.pending.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) no_idle = ($urandom_range(0, 2) == 0);
            send_query(random_query());
        end
        in_ch.valid <= 1'b0;

        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("%0d queries sent, %0d results checked, %0d degenerate",
                 sent, board.checked, board.degen_seen);
        $display("regions A %0d B %0d AB %0d C %0d AC %0d BC %0d interior %0d",
                 board.region_seen[0], board.region_seen[1], board.region_seen[2],
                 board.region_seen[3], board.region_seen[4], board.region_seen[5],
                 board.region_seen[6]);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("[closest_point_on_triangle] OK");
        end else begin
            $display("[closest_point_on_triangle] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/cpt_pkg.sv
design/cpt_in_if.sv
design/cpt_out_if.sv
design/cpt_mul.sv
design/cpt_div.sv
design/closest_point_on_triangle.sv
bench/tb_closest_point_on_triangle.sv
